### src/aes256_pkg.sv
// Package for the AES-256 block cipher: state types, S-box tables and
// GF(2^8) round helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aes256_pkg;

    localparam int NumKeyWords = 60;
    localparam int NumRounds   = 14;
    localparam int KeyIdxW     = 6;
    localparam int RoundW      = 4;
    localparam int CfgIdxW     = 2;

    localparam logic [CfgIdxW-1:0] CFG_KEY0 = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY1 = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY2 = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY3 = 2'd3;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_FETCH,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                kexp_init;
        logic                kexp_step;
        logic                load;
        logic                add_key;
        logic                do_round;
        logic                last_round;
        logic [RoundW-1:0]   rk_addr;
        logic                done;
    } t_cmd;

    typedef struct packed {
        logic                kexp_last;
    } t_status;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
    endfunction

    // bytes: byte 0 is state bits [127:120]; byte r+4c is row r, column c
    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        o = '0;
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : FWD_SBOX[s[127-8*i -: 8]];
        end
        return o;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        o = s;
        for (int r = 1; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) begin
                    o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
                end else begin
                    o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
                end
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        logic [7:0]   b0, b1, b2, b3;
        logic [7:0]   u, v;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            if (inv) begin
                u  = xtime(xtime(a0 ^ a2));
                v  = xtime(xtime(a1 ^ a3));
                a0 = a0 ^ u;
                a1 = a1 ^ v;
                a2 = a2 ^ u;
                a3 = a3 ^ v;
            end
            b0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            b1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            b2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            b3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            o[127-32*c -: 32] = {b0, b1, b2, b3};
        end
        return o;
    endfunction

endpackage
`default_nettype wire

### src/aes256_ctrl.sv
// Controller for the AES-256 block cipher: sequences key expansion and rounds.
// Depends on aes256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aes256_ctrl
    import aes256_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_go,
    input  wire logic    i_kind,
    input  wire logic    i_key_wr,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    t_state            r_state, n_state;
    logic              r_sched_ok, n_sched_ok;
    logic              r_dec, n_dec;
    logic [RoundW-1:0] r_round, n_round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_sched_ok <= 1'b0;
            r_dec      <= KIND_ENC;
            r_round    <= '0;
        end else begin
            r_state    <= n_state;
            r_sched_ok <= n_sched_ok;
            r_dec      <= n_dec;
            r_round    <= n_round;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sched_ok = r_sched_ok;
        n_dec      = r_dec;
        n_round    = r_round;
        case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    n_dec   = i_kind;
                    n_state = r_sched_ok ? ST_LOAD : ST_KEXP;
                end
            end
            ST_KEXP: begin
                if (i_status.kexp_last) begin
                    n_sched_ok = 1'b1;
                    n_state    = ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_LOAD;
            ST_LOAD: begin
                n_round = 4'd1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_round = r_round + 4'd1;
                if (r_round == RoundW'(NumRounds)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (i_key_wr) begin
            n_sched_ok = 1'b0;
        end
    end

    // round key index: the next round's number (the read is registered), counted down when decrypting
    always_comb begin
        o_cmd        = '0;
        o_busy       = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.kexp_init = i_go && !r_sched_ok;
                o_cmd.load      = i_go;
                o_cmd.rk_addr   = (i_kind == KIND_DEC) ? RoundW'(NumRounds) : '0;
            end
            ST_KEXP: begin
                o_cmd.kexp_step = 1'b1;
            end
            ST_FETCH: begin
                o_cmd.rk_addr = (r_dec == KIND_DEC) ? RoundW'(NumRounds) : '0;
            end
            ST_LOAD: begin
                o_cmd.add_key = 1'b1;
                o_cmd.rk_addr = (r_dec == KIND_DEC) ? RoundW'(NumRounds-1) : RoundW'(1);
            end
            ST_ROUND: begin
                o_cmd.do_round   = 1'b1;
                o_cmd.last_round = (r_round == RoundW'(NumRounds));
                if (r_round == RoundW'(NumRounds)) begin
                    o_cmd.rk_addr = '0;
                end else if (r_dec == KIND_DEC) begin
                    o_cmd.rk_addr = RoundW'(NumRounds - 1) - r_round;
                end else begin
                    o_cmd.rk_addr = r_round + 4'd1;
                end
            end
            ST_DONE: o_cmd.done = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

### src/aes256_dp.sv
// Datapath for the AES-256 block cipher: key schedule memory, key expander
// and one-round-per-cycle state register. Depends on aes256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aes256_dp
    import aes256_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic [255:0] i_key,
    input  wire logic         i_kind,
    input  wire logic [127:0] i_block,
    input  wire t_cmd         i_cmd,
    output t_status           o_status,
    output logic [127:0]      o_result
);

    logic [127:0]       r_mem [NumRounds+1];
    logic [127:0]       r_rk;
    logic [127:0]       r_state;
    logic               r_dec;
    logic [255:0]       r_win, n_win;
    logic [KeyIdxW-1:0] r_widx, n_widx;
    logic [7:0]         r_rcon, n_rcon;
    logic [31:0]        w_new, w_t;
    logic               w_wr;
    logic [127:0]       w_in, w_pre, w_mid, w_fwd, w_inv;
    logic [RoundW-1:0]  w_raddr;

    // expander keeps the last eight words in a window; window top is word i-8
    always_comb begin
        w_t = r_win[31:0];
        if (r_widx[2:0] == 3'd0) begin
            w_t = sub_word({w_t[23:0], w_t[31:24]}) ^ {r_rcon, 24'h0};
        end else if (r_widx[2:0] == 3'd4) begin
            w_t = sub_word(w_t);
        end
        w_new = r_win[255:224] ^ w_t;
        n_win  = r_win;
        n_widx = r_widx;
        n_rcon = r_rcon;
        w_wr   = 1'b0;
        if (i_cmd.kexp_init) begin
            n_win  = i_key;
            n_widx = '0;
            n_rcon = 8'h01;
        end else if (i_cmd.kexp_step) begin
            w_wr   = 1'b1;
            n_widx = r_widx + 1'b1;
            if (r_widx >= KeyIdxW'(8)) begin
                n_win = {r_win[223:0], w_new};
                if (r_widx[2:0] == 3'd0) begin
                    n_rcon = xtime(r_rcon);
                end
            end
        end
    end

    assign o_status.kexp_last = i_cmd.kexp_step && (r_widx == KeyIdxW'(NumKeyWords - 1));

    // word i lands in round key i/4, column i%4
    always_ff @(posedge i_clk) begin
        r_win  <= n_win;
        r_widx <= n_widx;
        r_rcon <= n_rcon;
        if (w_wr) begin
            r_mem[r_widx[5:2]][127 - 32*r_widx[1:0] -: 32] <=
                (r_widx < KeyIdxW'(8)) ? r_win[255 - 32*r_widx[2:0] -: 32] : w_new;
        end
    end

    // one whole round key per read, registered
    assign w_raddr = i_cmd.rk_addr;
    always_ff @(posedge i_clk) begin
        r_rk <= r_mem[w_raddr];
    end

    assign w_in  = r_state;
    assign w_fwd = shift_rows(sub_bytes(w_in, 1'b0), 1'b0);
    assign w_inv = sub_bytes(shift_rows(w_in, 1'b1), 1'b1);
    assign w_pre = (r_dec == KIND_DEC) ? w_inv : w_fwd;
    assign w_mid = (r_dec == KIND_DEC) ? (w_pre ^ r_rk) : w_pre;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dec   <= i_kind;
            r_state <= i_block;
        end else if (i_cmd.add_key) begin
            r_state <= r_state ^ r_rk;
        end else if (i_cmd.do_round) begin
            if (i_cmd.last_round) begin
                r_state <= (r_dec == KIND_DEC) ? w_mid : (w_pre ^ r_rk);
            end else if (r_dec == KIND_DEC) begin
                r_state <= mix_columns(w_mid, 1'b1);
            end else begin
                r_state <= mix_columns(w_pre, 1'b0) ^ r_rk;
            end
        end
    end

    assign o_result = r_state;

endmodule
`default_nettype wire

### src/aes256_block_cipher.sv
// Top level of the AES-256 block cipher: key registers, controller, datapath.
// Depends on aes256_pkg, aes256_ctrl and aes256_dp.
//
// One block per request: pulse start while busy is low. Results appear on
// o_out_hi/o_out_lo for one cycle with o_done; the receiver cannot stall.
// The result is presented after the initial key addition and fourteen rounds
// on one round unit, and only then does busy drop, so a new request is taken
// only once the previous result has been presented.
// The first request after reset or a key write first expands the 60-word
// schedule one word per cycle and reads back the first round key before
// the initial key addition.
`timescale 1ns / 1ps
`default_nettype none
module aes256_block_cipher
    import aes256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_kind,
    input  wire logic [63:0] i_block_hi,
    input  wire logic [63:0] i_block_lo,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_done,
    output logic [63:0]      o_out_hi,
    output logic [63:0]      o_out_lo
);

    logic [63:0]  r_key0, r_key1, r_key2, r_key3;
    t_cmd         w_cmd;
    t_status      w_status;
    logic [127:0] w_result;
    logic         w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY0: r_key0 <= i_cfg_data;
                CFG_KEY1: r_key1 <= i_cfg_data;
                CFG_KEY2: r_key2 <= i_cfg_data;
                CFG_KEY3: r_key3 <= i_cfg_data;
                default:  r_key0 <= r_key0;
            endcase
        end
    end

    assign w_go = start && !busy;

    aes256_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_kind   (i_kind),
        .i_key_wr (i_cfg_we),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    aes256_dp u_dp (
        .i_clk    (i_clk),
        .i_key    ({r_key0, r_key1, r_key2, r_key3}),
        .i_kind   (i_kind),
        .i_block  ({i_block_hi, i_block_lo}),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_result (w_result)
    );

    assign o_done   = w_cmd.done;
    assign o_out_hi = w_result[127:64];
    assign o_out_lo = w_result[63:0];

endmodule
`default_nettype wire

### src/aes256_checker.sv
// Port-level checker for the AES-256 block cipher, bound to the top level.
// Depends on aes256_block_cipher ports only.
`timescale 1ns / 1ps
`default_nettype none
module aes256_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done
);

    a_busy_after_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request not taken");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result without a request in flight");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result");

endmodule

bind aes256_block_cipher aes256_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
`default_nettype wire

### verif/aes256_block_cipher_test.sv
// Self-checking test of the AES-256 block cipher: known vectors, key changes
// and random blocks, checked against stored results or a cipher model held in this module.
// Depends on aes256_pkg and aes256_block_cipher.
`timescale 1ns / 1ps
module aes256_block_cipher_test
    import aes256_pkg::*;
;

    localparam int CycleLimit = 500000;
    localparam int DrainCycles = 40;

    typedef struct {
        logic        kind;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_request;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_block;

    typedef struct {
        logic        kind;
        logic [63:0] hi;
        logic [63:0] lo;
        bit          known;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } t_vector;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = KIND_ENC;
    logic [63:0] i_block_hi = '0;
    logic [63:0] i_block_lo = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_KEY0;
    logic [63:0] i_cfg_data = '0;
    logic        o_done;
    logic [63:0] o_out_hi;
    logic [63:0] o_out_lo;

    aes256_block_cipher i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_kind, .i_block_hi, .i_block_lo,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_done, .o_out_hi, .o_out_lo
    );

    always #4 i_clk = ~i_clk;

    // cipher model state
    logic [7:0]  sbox [256];
    logic [7:0]  sbox_inv [256];
    logic [63:0] key_reg [4];
    logic [31:0] sched [60];
    bit          sched_ok;
    logic [7:0]  st [16];

    t_block      pending_q [$];
    bit          failed;
    int unsigned cycles;

    function automatic logic [7:0] gf2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf2(a);
        end
        return acc;
    endfunction

    function void build_sbox();
        logic [7:0] x, y, s;
        for (int i = 0; i < 256; i++) begin
            x = 8'(i);
            y = '0;
            for (int j = 1; j < 256; j++) begin
                if (gmul(x, 8'(j)) == 8'h01) y = 8'(j);
            end
            s = y ^ {y[6:0], y[7]} ^ {y[5:0], y[7:6]} ^ {y[4:0], y[7:5]}
                ^ {y[3:0], y[7:4]} ^ 8'h63;
            sbox[i] = s;
            sbox_inv[s] = x;
        end
    endfunction

    function automatic logic [31:0] sub32(input logic [31:0] w);
        return {sbox[w[31:24]], sbox[w[23:16]], sbox[w[15:8]], sbox[w[7:0]]};
    endfunction

    function void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) sched[i] = key_reg[i/2][(i%2 ? 31 : 63) -: 32];
        for (int i = 8; i < 60; i++) begin
            t = sched[i-1];
            if (i % 8 == 0) begin
                t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf2(rc);
            end else if (i % 8 == 4) begin
                t = sub32(t);
            end
            sched[i] = sched[i-8] ^ t;
        end
        sched_ok = 1'b1;
    endfunction

    function void add_round_key(input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                st[r+4*c] ^= sched[rnd*4+c][31-8*r -: 8];
    endfunction

    function void sub_state(input bit inv);
        for (int i = 0; i < 16; i++) st[i] = inv ? sbox_inv[st[i]] : sbox[st[i]];
    endfunction

    function void rotate_rows(input bit inv);
        logic [7:0] t [16];
        t = st;
        for (int r = 1; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                if (inv) st[r+4*((c+r)%4)] = t[r+4*c];
                else st[r+4*c] = t[r+4*((c+r)%4)];
            end
    endfunction

    function void mix_state(input bit inv);
        logic [7:0] col [4];
        logic [7:0] cf [4];
        logic [7:0] v;
        if (inv) cf = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else cf = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = st[k+4*c];
            for (int r = 0; r < 4; r++) begin
                v = '0;
                for (int k = 0; k < 4; k++) v ^= gmul(col[k], cf[(k-r+4)%4]);
                st[r+4*c] = v;
            end
        end
    endfunction

    function t_block cipher_block(input t_request rq);
        t_block res;
        if (!sched_ok) expand_schedule();
        for (int i = 0; i < 8; i++) begin
            st[i]   = rq.hi[63-8*i -: 8];
            st[i+8] = rq.lo[63-8*i -: 8];
        end
        if (rq.kind == KIND_ENC) begin
            add_round_key(0);
            for (int rnd = 1; rnd < 14; rnd++) begin
                sub_state(0); rotate_rows(0); mix_state(0); add_round_key(rnd);
            end
            sub_state(0); rotate_rows(0); add_round_key(14);
        end else begin
            add_round_key(14);
            for (int rnd = 13; rnd > 0; rnd--) begin
                rotate_rows(1); sub_state(1); add_round_key(rnd); mix_state(1);
            end
            rotate_rows(1); sub_state(1); add_round_key(0);
        end
        for (int i = 0; i < 8; i++) begin
            res.hi[63-8*i -: 8] = st[i];
            res.lo[63-8*i -: 8] = st[i+8];
        end
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result out_hi=%h out_lo=%h", o_out_hi, o_out_lo);
                failed = 1'b1;
            end else begin
                want = pending_q.pop_front();
                if (o_out_hi !== want.hi) begin
                    $error("out_hi expected %h actual %h", want.hi, o_out_hi);
                    failed = 1'b1;
                end
                if (o_out_lo !== want.lo) begin
                    $error("out_lo expected %h actual %h", want.lo, o_out_lo);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic idle_burst();
        repeat ($urandom_range(1, 17)) @(negedge i_clk);
    endtask

    task automatic send_request(input t_request rq, input bit known, input t_block fixed);
        t_block model;
        while (busy) @(negedge i_clk);
        model = cipher_block(rq);
        pending_q.push_back(known ? fixed : model);
        start = 1'b1;
        i_kind = rq.kind;
        i_block_hi = rq.hi;
        i_block_lo = rq.lo;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        while (pending_q.size() != 0 || busy) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        key_reg[idx] = val;
        sched_ok = 1'b0;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    t_vector vectors [] = '{
        '{KIND_ENC, 64'h0, 64'h0, 1'b1, 64'hdc95c078a2408989, 64'had48a21492842087},
        '{KIND_DEC, 64'hdc95c078a2408989, 64'had48a21492842087, 1'b1, 64'h0, 64'h0},
        '{KIND_ENC, '1, '1, 1'b0, 64'h0, 64'h0},
        '{KIND_DEC, '1, '1, 1'b0, 64'h0, 64'h0},
        '{KIND_DEC, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
        '{KIND_ENC, 64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0}
    };
    t_vector fips_vectors [] = '{
        '{KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
          64'h8ea2b7ca516745bf, 64'heafc49904b496089},
        '{KIND_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1,
          64'h0011223344556677, 64'h8899aabbccddeeff},
        '{KIND_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
        '{KIND_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0}
    };

    initial begin
        t_request rq;
        t_block   fixed;
        int       n;
        failed = 1'b0;
        cycles = 0;
        sched_ok = 1'b0;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        build_sbox();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (vectors[i]) begin
            rq = '{vectors[i].kind, vectors[i].hi, vectors[i].lo};
            fixed = '{vectors[i].exp_hi, vectors[i].exp_lo};
            send_request(rq, vectors[i].known, fixed);
        end
        write_key(CFG_KEY0, 64'h0001020304050607);
        write_key(CFG_KEY1, 64'h08090a0b0c0d0e0f);
        write_key(CFG_KEY2, 64'h1011121314151617);
        write_key(CFG_KEY3, 64'h18191a1b1c1d1e1f);
        foreach (fips_vectors[i]) begin
            rq = '{fips_vectors[i].kind, fips_vectors[i].hi, fips_vectors[i].lo};
            fixed = '{fips_vectors[i].exp_hi, fips_vectors[i].exp_lo};
            send_request(rq, fips_vectors[i].known, fixed);
        end
        // partial key update, then all-ones key
        write_key(CFG_KEY2, '1);
        send_request('{KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff}, 1'b0, fixed);
        for (int i = 0; i < 4; i++) write_key(2'(i), '1);
        send_request('{KIND_ENC, '1, '0}, 1'b0, fixed);
        send_request('{KIND_DEC, '0, '1}, 1'b0, fixed);

        n = 0;
        while (n < 400) begin
            if (n % 50 == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    write_key(2'($urandom_range(0, 3)), rand_word());
                end else begin
                    for (int i = 0; i < 4; i++) write_key(2'(i), rand_word());
                end
            end
            rq = '{1'($urandom_range(0, 1)), rand_word(), rand_word()};
            send_request(rq, 1'b0, fixed);
            if (n < 340 && $urandom_range(0, 3) == 0) idle_burst();
            n++;
        end

        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (!failed) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
